>>> design/satl_pkg.sv
// ----------------------------------------------------------------------------
// satl_pkg: shared types and constants of the cache tag directory
// Controller state, command and status bundles, and item field codes.
// ----------------------------------------------------------------------------
`default_nettype none

package satl_pkg;

   // Width of every address field on the item ports
   localparam int FIELD_W = 48;

   // Item kind codes
   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_INVAL  = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // capture item, issue set read
      logic commit;   // write set back, load result
      logic clear;    // write reset row during clearing pass
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;   // clearing pass is on its final row
   } status_type;

endpackage

`default_nettype wire

>>> design/set_assoc_cache_tags_lru_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tags_lru_top: set-associative cache tag directory, true LRU
// Looks up, fills and invalidates line tags per set and keeps a full
// recency order per set; reports misses and, optionally, evicted lines.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             carries
//   req_      in         req_valid/req_stall   kind, byte address
//   rsp_      out        rsp_valid/rsp_stall   hit, miss line, victim line
//   csr_      in         csr_valid/csr_ready   report_evictions bit
//
// An item is accepted with a set read; then, in the lookup state, the set is
// looked up, its row written back and the result loaded. The read-modify-write of
// the set memories sets this order; a stalled result holds the lookup state.
// After reset a clearing pass writes every set row, 2**floor(log2(SETS)) rows
// (64 at the defaults), with req_stall high throughout.
// A new item is taken while an earlier result still waits on rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tags_lru_top #(
   parameter int SETS       = 64,
   parameter int WAYS       = 4,
   parameter int LINE_BYTES = 64,
   parameter int ADDR_BITS  = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_kind,
   input  wire logic [satl_pkg::FIELD_W-1:0]  req_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_hit,
   output logic      [satl_pkg::FIELD_W-1:0]  rsp_miss_line_address,
   output logic                               rsp_victim_valid,
   output logic      [satl_pkg::FIELD_W-1:0]  rsp_victim_address,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_data
);

   satl_pkg::cmd_type    cmd;
   satl_pkg::status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   satl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   satl_dpath #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_kind              (req_kind),
      .req_address           (req_address),
      .csr_valid             (csr_valid),
      .csr_data              (csr_data),
      .rsp_hit               (rsp_hit),
      .rsp_miss_line_address (rsp_miss_line_address),
      .rsp_victim_valid      (rsp_victim_valid),
      .rsp_victim_address    (rsp_victim_address)
   );

endmodule

`default_nettype wire

>>> design/satl_ram.sv
// ----------------------------------------------------------------------------
// satl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered, held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module satl_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/satl_ctrl.sv
// ----------------------------------------------------------------------------
// satl_ctrl: sequencer of the cache tag directory
// Runs the clearing pass, accepts items, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module satl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output satl_pkg::cmd_type         cmd,
   input  wire satl_pkg::status_type status
);

   satl_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   // State and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= satl_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      cmd.clear  = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         satl_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = satl_pkg::ST_IDLE;
            end
         end
         satl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = satl_pkg::ST_LOOKUP;
            end
         end
         satl_pkg::ST_LOOKUP: begin
            // hold the set read data until the output register frees up
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = satl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = satl_pkg::ST_CLEAR;
         end
      endcase
   end

   // Set on commit, drop once taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/satl_dpath.sv
// ----------------------------------------------------------------------------
// satl_dpath: tag and recency datapath of the cache tag directory
// Holds the set memories, the item registers, the lookup and LRU update
// logic, the eviction reporting flag and the result payload registers.
// ----------------------------------------------------------------------------
`default_nettype none

module satl_dpath #(
   parameter int SETS       = 64,
   parameter int WAYS       = 4,
   parameter int LINE_BYTES = 64,
   parameter int ADDR_BITS  = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire satl_pkg::cmd_type             cmd,
   output satl_pkg::status_type               status,
   input  wire logic                          req_kind,
   input  wire logic [satl_pkg::FIELD_W-1:0]  req_address,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_data,
   output logic                               rsp_hit,
   output logic      [satl_pkg::FIELD_W-1:0]  rsp_miss_line_address,
   output logic                               rsp_victim_valid,
   output logic      [satl_pkg::FIELD_W-1:0]  rsp_victim_address
);

   localparam int FW     = satl_pkg::FIELD_W;
   localparam int OFF_W  = $clog2(LINE_BYTES + 1) - 1;
   localparam int IDX_W  = $clog2(SETS + 1) - 1;
   localparam int NSETS  = 1 << IDX_W;
   localparam int IDX_AW = (IDX_W > 0) ? IDX_W : 1;
   localparam int EFF_W  = (ADDR_BITS < FW) ? ADDR_BITS : FW;
   localparam int LOW_W  = OFF_W + IDX_W;
   localparam int TAG_W  = (EFF_W > LOW_W) ? (EFF_W - LOW_W) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int META_W = WAYS + WAYS * WAY_W;
   localparam int TROW_W = WAYS * TAG_W;

   localparam logic [FW-1:0] EFF_MASK = {FW{1'b1}} >> (FW - EFF_W);
   localparam logic [FW-1:0] LINE_MASK = {FW{1'b1}} << OFF_W;
   localparam logic [FW-1:0] SET_MASK = FW'(NSETS - 1);

   // Item registers
   logic              kind_ff;
   logic [FW-1:0]     addr_ff;
   logic [IDX_AW-1:0] set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [FW-1:0]     req_masked;

   // Configuration and clearing pass
   logic              report_ff;
   logic [IDX_AW-1:0] clear_idx_ff;

   // Result payload registers
   logic              hit_ff, hit_in;
   logic [FW-1:0]     miss_addr_ff, miss_addr_in;
   logic              vic_valid_ff, vic_valid_in;
   logic [FW-1:0]     vic_addr_ff, vic_addr_in;

   // Memory ports
   logic [TROW_W-1:0] tag_rd, tag_wr;
   logic [META_W-1:0] meta_rd, meta_wr;
   logic              tag_we, meta_we;
   logic [IDX_AW-1:0] rd_set, meta_waddr;

   // Lookup signals
   logic [WAYS-1:0]   vld, new_vld;
   logic [WAY_W-1:0]  ord [WAYS];
   logic [WAY_W-1:0]  new_ord [WAYS];
   logic [TAG_W-1:0]  tags [WAYS];
   logic              hit_any;
   logic [WAY_W-1:0]  hit_way, lru_way, tgt_way, pos;
   logic              fill;

   // Split the incoming address
   assign req_masked = req_address & EFF_MASK;
   assign rd_set     = IDX_AW'((req_masked >> OFF_W) & SET_MASK);

   // Capture the item on accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         addr_ff <= req_masked;
         set_ff  <= rd_set;
         tag_ff  <= TAG_W'(req_masked >> LOW_W);
      end
   end

   // Eviction reporting flag
   always_ff @(posedge clock) begin
      if (reset) begin
         report_ff <= 1'b0;
      end else if (csr_valid) begin
         report_ff <= csr_data;
      end
   end

   // Advance the clearing row
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   assign status.clear_last = (clear_idx_ff == IDX_AW'(NSETS - 1));

   // Unpack the set read data
   always_comb begin
      vld = meta_rd[WAYS-1:0];
      for (int p = 0; p < WAYS; p++) begin
         ord[p]  = meta_rd[WAYS + p*WAY_W +: WAY_W];
         tags[p] = tag_rd[p*TAG_W +: TAG_W];
      end
   end

   // Tag match, lowest matching way wins
   always_comb begin
      hit_any = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (vld[w] && (tags[w] == tag_ff)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   assign lru_way = ord[WAYS-1];
   assign tgt_way = hit_any ? hit_way : lru_way;
   assign fill    = (kind_ff == satl_pkg::KIND_ACCESS) && !hit_any;

   // Position of the target way in the recency order
   always_comb begin
      pos = '0;
      for (int p = 0; p < WAYS; p++) begin
         if (ord[p] == tgt_way) begin
            pos = WAY_W'(p);
         end
      end
   end

   // New recency order and valid bits
   always_comb begin
      new_vld = vld;
      for (int p = 0; p < WAYS; p++) begin
         new_ord[p] = ord[p];
      end
      if (kind_ff == satl_pkg::KIND_INVAL) begin
         // invalidate hit: clear and move to the LRU tail
         if (hit_any) begin
            new_vld[hit_way] = 1'b0;
            for (int p = 0; p < WAYS - 1; p++) begin
               if (WAY_W'(p) >= pos) begin
                  new_ord[p] = ord[p+1];
               end
            end
            new_ord[WAYS-1] = tgt_way;
         end
      end else begin
         // access: hit way or victim becomes MRU
         if (!hit_any) begin
            new_vld[lru_way] = 1'b1;
         end
         for (int p = 1; p < WAYS; p++) begin
            if (WAY_W'(p) <= pos) begin
               new_ord[p] = ord[p-1];
            end
         end
         new_ord[0] = tgt_way;
      end
   end

   // Write-back data for both memories
   always_comb begin
      meta_wr[WAYS-1:0] = cmd.clear ? '0 : new_vld;
      for (int p = 0; p < WAYS; p++) begin
         meta_wr[WAYS + p*WAY_W +: WAY_W] = cmd.clear ? WAY_W'(p) : new_ord[p];
         tag_wr[p*TAG_W +: TAG_W] = (WAY_W'(p) == lru_way) ? tag_ff : tags[p];
      end
   end

   assign meta_we    = cmd.commit || cmd.clear;
   assign meta_waddr = cmd.clear ? clear_idx_ff : set_ff;
   assign tag_we     = cmd.commit && fill;

   // Result fields
   always_comb begin
      hit_in       = hit_any;
      miss_addr_in = '0;
      vic_valid_in = 1'b0;
      vic_addr_in  = '0;
      if (fill) begin
         miss_addr_in = addr_ff & LINE_MASK;
         vic_valid_in = report_ff && vld[lru_way];
         if (vic_valid_in) begin
            vic_addr_in = ((FW'(tags[lru_way]) << LOW_W) |
                           ((FW'(set_ff) & SET_MASK) << OFF_W)) & EFF_MASK;
         end
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff       <= hit_in;
         miss_addr_ff <= miss_addr_in;
         vic_valid_ff <= vic_valid_in;
         vic_addr_ff  <= vic_addr_in;
      end
   end

   assign rsp_hit               = hit_ff;
   assign rsp_miss_line_address = miss_addr_ff;
   assign rsp_victim_valid      = vic_valid_ff;
   assign rsp_victim_address    = vic_addr_ff;

   // Tags of all ways of a set, one row per set
   satl_ram #(
      .WIDTH (TROW_W),
      .DEPTH (NSETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (set_ff),
      .wr_data (tag_wr),
      .rd_en   (cmd.accept),
      .rd_addr (rd_set),
      .rd_data (tag_rd)
   );

   // Valid bits and recency order of a set, one row per set
   satl_ram #(
      .WIDTH (META_W),
      .DEPTH (NSETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wr),
      .rd_en   (cmd.accept),
      .rd_addr (rd_set),
      .rd_data (meta_rd)
   );

endmodule

`default_nettype wire

>>> design/satl_checker.sv
// ----------------------------------------------------------------------------
// satl_checker: port-level checks of the cache tag directory
// Watches the item channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module satl_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_hit,
   input wire logic [satl_pkg::FIELD_W-1:0]  rsp_miss_line_address,
   input wire logic                          rsp_victim_valid,
   input wire logic [satl_pkg::FIELD_W-1:0]  rsp_victim_address
);

   // A stalled result stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) &&
         $stable(rsp_miss_line_address) && $stable(rsp_victim_valid) &&
         $stable(rsp_victim_address))
      else $error("stalled result item changed");

   // One item at a time: the cycle after an accept is busy
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous item in flight");

   // A hit carries no miss or victim report
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_victim_valid && (rsp_miss_line_address == '0))
      else $error("hit item carries miss or victim fields");

   // No victim address without a victim
   a_victim_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_victim_valid |-> (rsp_victim_address == '0))
      else $error("victim address without victim flag");

endmodule

bind set_assoc_cache_tags_lru_top satl_checker u_satl_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_hit               (rsp_hit),
   .rsp_miss_line_address (rsp_miss_line_address),
   .rsp_victim_valid      (rsp_victim_valid),
   .rsp_victim_address    (rsp_victim_address)
);

`default_nettype wire

>>> tb/set_assoc_cache_tags_lru_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tags_lru_top_tb: tag directory with true LRU, self-checking
// Drives access and invalidate items through the request channel, keeps its
// own copy of every set's tags, valid bits and recency order, and checks each
// result against the expected hit, miss line and victim line, in order.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

// Expected or observed contents of one result item
typedef struct packed {
   logic                          hit;
   logic [satl_pkg::FIELD_W-1:0]  miss_line_address;
   logic                          victim_valid;
   logic [satl_pkg::FIELD_W-1:0]  victim_address;
} lookup_result_type;

// Tag directory shadow and in-order result check
class lru_board_type;
   localparam int FW    = satl_pkg::FIELD_W;
   localparam int NSETS = 64;
   localparam int NWAYS = 4;
   localparam int OFF_W = 6;
   localparam int IDX_W = 6;
   localparam int TAG_W = FW - OFF_W - IDX_W;

   bit                 way_valid [NSETS][NWAYS];
   logic [TAG_W-1:0]   way_tag   [NSETS][NWAYS];
   logic [1:0]         recency   [NSETS][NWAYS];   // index 0 is MRU
   bit                 report_evictions;
   lookup_result_type  awaited_results[$];
   int                 errors;
   int                 n_items, n_hits, n_misses, n_evictions, n_cleared;

   function new();
      for (int s = 0; s < NSETS; s++) begin
         for (int w = 0; w < NWAYS; w++) begin
            way_valid[s][w] = 1'b0;
            way_tag[s][w]   = '0;
            recency[s][w]   = w[1:0];
         end
      end
      report_evictions = 1'b0;
      errors = 0;
      n_items = 0;
      n_hits = 0;
      n_misses = 0;
      n_evictions = 0;
      n_cleared = 0;
   endfunction

   // Move a way to the head of its set's recency order
   function void promote(logic [IDX_W-1:0] set_idx, logic [1:0] way);
      int pos;
      pos = 0;
      for (int i = 0; i < NWAYS; i++)
         if (recency[set_idx][i] == way) pos = i;
      for (int i = pos; i > 0; i--)
         recency[set_idx][i] = recency[set_idx][i-1];
      recency[set_idx][0] = way;
   endfunction

   // Work out the result of an accepted item and update the shadow state
   function void note_request(logic kind, logic [FW-1:0] address);
      lookup_result_type r;
      logic [IDX_W-1:0]  set_idx;
      logic [TAG_W-1:0]  tag;
      logic [1:0]        hit_way;
      logic [1:0]        victim;
      bit                found;
      int                pos;
      r       = '0;
      set_idx = address[OFF_W +: IDX_W];
      tag     = address[FW-1 -: TAG_W];
      found   = 1'b0;
      hit_way = '0;
      for (int w = NWAYS - 1; w >= 0; w--) begin
         if (way_valid[set_idx][w] && way_tag[set_idx][w] == tag) begin
            found   = 1'b1;
            hit_way = w[1:0];
         end
      end
      n_items++;
      if (kind == satl_pkg::KIND_INVAL) begin
         // Clear the line and sink it to the LRU tail
         if (found) begin
            way_valid[set_idx][hit_way] = 1'b0;
            pos = 0;
            for (int i = 0; i < NWAYS; i++)
               if (recency[set_idx][i] == hit_way) pos = i;
            for (int i = pos; i < NWAYS - 1; i++)
               recency[set_idx][i] = recency[set_idx][i+1];
            recency[set_idx][NWAYS-1] = hit_way;
            r.hit = 1'b1;
            n_cleared++;
         end
      end else if (found) begin
         promote(set_idx, hit_way);
         r.hit = 1'b1;
         n_hits++;
      end else begin
         // Miss: replace the LRU tail and report the victim if asked to
         r.miss_line_address = {address[FW-1:OFF_W], {OFF_W{1'b0}}};
         victim = recency[set_idx][NWAYS-1];
         if (report_evictions && way_valid[set_idx][victim]) begin
            r.victim_valid   = 1'b1;
            r.victim_address = {way_tag[set_idx][victim], set_idx, {OFF_W{1'b0}}};
            n_evictions++;
         end
         way_valid[set_idx][victim] = 1'b1;
         way_tag[set_idx][victim]   = tag;
         promote(set_idx, victim);
         n_misses++;
      end
      awaited_results.push_back(r);
   endfunction

   function void compare_field(string name, logic [FW-1:0] expv,
                               logic [FW-1:0] actv);
      if (actv !== expv) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, expv, actv);
      end
   endfunction

   // Compare a result item with the oldest expectation
   function void check_response(lookup_result_type got);
      lookup_result_type exp_r;
      if (awaited_results.size() == 0) begin
         errors++;
         $display("%0t: result with none expected, expected none actual %h", $time, got);
         return;
      end
      exp_r = awaited_results.pop_front();
      compare_field("hit", FW'(exp_r.hit), FW'(got.hit));
      compare_field("miss_line_address", exp_r.miss_line_address, got.miss_line_address);
      compare_field("victim_valid", FW'(exp_r.victim_valid), FW'(got.victim_valid));
      compare_field("victim_address", exp_r.victim_address, got.victim_address);
   endfunction
endclass

module set_assoc_cache_tags_lru_top_tb;

   localparam int FW = satl_pkg::FIELD_W;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic          req_kind;
   logic [FW-1:0] req_address;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_hit;
   logic [FW-1:0] rsp_miss_line_address;
   logic          rsp_victim_valid;
   logic [FW-1:0] rsp_victim_address;
   logic          csr_valid;
   logic          csr_ready;
   logic          csr_data;

   lru_board_type board = new();

   int             burst_left = 0;
   bit             sender_idles = 1'b1;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_mode_left = 0;

   set_assoc_cache_tags_lru_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_address           (req_address),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hit               (rsp_hit),
      .rsp_miss_line_address (rsp_miss_line_address),
      .rsp_victim_valid      (rsp_victim_valid),
      .rsp_victim_address    (rsp_victim_address),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin
      #2_000_000;
      $display("Timed out with %0d results outstanding", board.awaited_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   // Observe handshakes at the rising edge
   always @(posedge clock) begin
      lookup_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_kind, req_address);
         if (rsp_valid && !rsp_stall) begin
            got.hit               = rsp_hit;
            got.miss_line_address = rsp_miss_line_address;
            got.victim_valid      = rsp_victim_valid;
            got.victim_address    = rsp_victim_address;
            board.check_response(got);
         end
         if (csr_valid && csr_ready) board.report_evictions = csr_data;
      end
   end

   // Receiver stall pattern: switch between modes at random times
   always @(negedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = stall_mode_type'($urandom_range(0, 3));
         stall_mode_left = $urandom_range(10, 80);
      end
      stall_mode_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall = 1'b0;
         STALL_LIGHT: rsp_stall = ($urandom_range(0, 99) < 30);
         STALL_HEAVY: rsp_stall = ($urandom_range(0, 99) < 85);
         default:     rsp_stall = ~rsp_stall;
      endcase
   end

   function automatic logic [FW-1:0] line_addr(logic [35:0] tag, logic [5:0] set_idx,
                                               logic [5:0] offset);
      return {tag, set_idx, offset};
   endfunction

   // Drop valid for the given idle span, with junk on the payload
   task automatic idle_cycles(int n);
      @(negedge clock);
      req_valid   = 1'b0;
      req_kind    = 1'($urandom);
      req_address = {16'($urandom), 32'($urandom)};
      repeat (n - 1) @(negedge clock);
   endtask

   // Offer one item and hold it until accepted
   task automatic send_item(logic kind, logic [FW-1:0] address);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_idles && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
      burst_left--;
      @(negedge clock);
      req_valid   = 1'b1;
      req_kind    = kind;
      req_address = address;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_report_evictions(bit value);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Mostly a small pool of tags over a few sets, so hits and evictions are
   // common; the rest fully random addresses
   task automatic run_random(int count);
      logic [35:0]   tag_pool [6];
      logic [5:0]    set_pool [4];
      logic [FW-1:0] address;
      logic          kind;
      for (int i = 0; i < 6; i++) tag_pool[i] = {4'($urandom), 32'($urandom)};
      for (int i = 0; i < 4; i++) set_pool[i] = 6'($urandom);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 15)
            address = {16'($urandom), 32'($urandom)};
         else
            address = line_addr(tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)],
                                6'($urandom));
         kind = ($urandom_range(0, 99) < 20) ? satl_pkg::KIND_INVAL : satl_pkg::KIND_ACCESS;
         send_item(kind, address);
      end
   endtask

   // Stimulus
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = satl_pkg::KIND_ACCESS;
      req_address = '0;
      csr_valid   = 1'b0;
      csr_data    = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reporting off: extremes, hit after fill, invalidate hit and miss
      write_report_evictions(1'b0);
      send_item(satl_pkg::KIND_ACCESS, '0);
      send_item(satl_pkg::KIND_ACCESS, '0);
      send_item(satl_pkg::KIND_ACCESS, {FW{1'b1}});
      send_item(satl_pkg::KIND_INVAL, {FW{1'b1}});
      send_item(satl_pkg::KIND_INVAL, {FW{1'b1}});
      send_item(satl_pkg::KIND_ACCESS, FW'(6'h3f));
      // Overfill one set silently, then return to the evicted tag
      for (int t = 1; t <= 5; t++)
         send_item(satl_pkg::KIND_ACCESS, line_addr(36'(t), 6'd5, 6'd0));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'd1, 6'd5, 6'd17));

      // Reporting on: victim lines, and a fill into an invalidated way
      write_report_evictions(1'b1);
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'haaaaaaaaa, 6'd63, 6'd0));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'h555555555, 6'd63, 6'd63));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'hffffffffe, 6'd63, 6'd1));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'h000000000, 6'd63, 6'd2));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'h123456789, 6'd63, 6'd3));
      send_item(satl_pkg::KIND_INVAL,  line_addr(36'hffffffffe, 6'd63, 6'd4));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'hf0f0f0f0f, 6'd63, 6'd5));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'h555555555, 6'd63, 6'd6));
      send_item(satl_pkg::KIND_ACCESS, line_addr(36'h0f0f0f0f0, 6'd63, 6'd7));

      // Random phases across both settings, one without sender gaps
      run_random(150);
      write_report_evictions(1'b0);
      sender_idles = 1'b0;
      run_random(120);
      sender_idles = 1'b1;
      write_report_evictions(1'b1);
      run_random(130);
      write_report_evictions(1'b0);
      run_random(100);

      drain();
      repeat (8) @(posedge clock);
      if (board.awaited_results.size() != 0) begin
         board.errors += board.awaited_results.size();
         $display("%0t: %0d results never arrived", $time, board.awaited_results.size());
      end
      $display("Ran %0d items: %0d hits, %0d misses, %0d reported evictions, %0d lines cleared",
               board.n_items, board.n_hits, board.n_misses, board.n_evictions, board.n_cleared);
      $display("Both eviction settings used, with sender gaps and receiver stalls varied");
      if (board.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> set_assoc_cache_tags_lru_top.f
design/satl_pkg.sv
design/satl_ram.sv
design/satl_ctrl.sv
design/satl_dpath.sv
design/set_assoc_cache_tags_lru_top.sv
design/satl_checker.sv
tb/set_assoc_cache_tags_lru_top_tb.sv
